// ===== sv/gdsd_pkg.sv =====
`default_nettype none

package gdsd_pkg;

    localparam int AXIS_NUM = 3;
    localparam int AXIS_W   = 2;
    localparam int CMD_W    = 2;
    localparam int VAL_W    = 16;
    localparam int CNT_W    = 6;
    localparam int THR_W    = 9;
    localparam int TICK_W   = 15;
    localparam int CFG_W    = 15;

    // register indexes of the configuration port
    localparam logic CFG_DELTA_THRESHOLD = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS   = 1'b1;

    localparam logic [THR_W-1:0]  DELTA_THRESHOLD_RST = 9'd160;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST   = 15'd10000;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEED   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_t;

    // strobes and data from the control path to one axis lane
    typedef struct packed {
        logic                    seed;
        logic                    sample;
        logic signed [VAL_W-1:0] value;
    } lane_cmd_t;

    // what one axis lane reports back for the item being applied
    typedef struct packed {
        logic             done;
        logic             closed;
        logic [VAL_W-1:0] range;
    } lane_stat_t;

endpackage

`default_nettype wire

// ===== sv/gdsd_axis_lane.sv =====
`default_nettype none

module gdsd_axis_lane
    import gdsd_pkg::*;
#(
    parameter int WINDOW_SIZE = 50
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lane_cmd_t        cmd,
    input  wire logic [THR_W-1:0] delta_threshold,
    output      lane_stat_t       stat
);

    localparam logic [CNT_W-1:0] WIN_FULL = CNT_W'(WINDOW_SIZE);

    logic signed [VAL_W-1:0] min_reg, min_next;
    logic signed [VAL_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    done_reg, done_next;

    logic                    win_full;
    logic                    active;
    logic [VAL_W:0]          diff;
    logic [VAL_W-1:0]        range;
    logic                    settle;
    logic signed [VAL_W-1:0] base_min, base_max;
    logic [CNT_W-1:0]        base_cnt;

    always_comb
    begin
        win_full = (count_reg == WIN_FULL);
        active   = cmd.sample && !done_reg;
        // max never drops below min, so the difference fits in 16 bits
        diff     = {max_reg[VAL_W-1], max_reg} - {min_reg[VAL_W-1], min_reg};
        range    = diff[VAL_W-1:0];
        settle   = (range != '0) && (range < VAL_W'(delta_threshold));

        // a full window restarts at the sample
        base_min = win_full ? cmd.value : min_reg;
        base_max = win_full ? cmd.value : max_reg;
        base_cnt = win_full ? '0 : count_reg;

        min_next   = min_reg;
        max_next   = max_reg;
        count_next = count_reg;
        done_next  = done_reg;

        if (cmd.seed)
        begin
            min_next   = cmd.value;
            max_next   = cmd.value;
            count_next = '0;
            done_next  = 1'b0;
        end
        else if (active)
        begin
            min_next   = (cmd.value < base_min) ? cmd.value : base_min;
            max_next   = (cmd.value > base_max) ? cmd.value : base_max;
            count_next = base_cnt + CNT_W'(1);
            if (win_full && settle)
            begin
                done_next = 1'b1;
            end
        end

        stat.done   = done_next;
        stat.closed = active && win_full;
        stat.range  = (active && win_full) ? range : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            max_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gyro_drift_settle_detector_core.sv =====
// Three-axis gyro drift settle detector. Seed, sample and tick transfers enter on the
// s_axis side and each one yields exactly one status transfer on the m_axis side, in
// order. An accepted transfer is held in the input register, is applied to the
// per-axis min/max/count state and the run control as it leaves that register, and its
// status lands in the result register at the same clock edge; m_axis_tvalid comes
// from the result register. A new transfer is accepted every cycle while the result
// side keeps up. The rate is set by the read-modify-write of the axis state: each
// lane does one 17-bit subtract, one threshold compare and two min/max compares per
// transfer. A stalled result side holds the input register and then s_axis_tready.
// Configuration writes take effect at once and are meant for times when no transfer
// is in flight.
`default_nettype none

module gyro_drift_settle_detector_core
    import gdsd_pkg::*;
#(
    parameter int WINDOW_SIZE = 50
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [14:0] cfg_wdata,

    // input stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // drift_value
    input  wire logic [3:0]  s_axis_tuser,  // command, axis

    // result stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,  // done_x, done_y, done_z, all_done,
                                            // timed_out, window_range, zero pad
    output      logic        m_axis_tuser   // window_closed
);

    // configuration registers
    logic [THR_W-1:0]  threshold_reg;
    logic [TICK_W-1:0] timeout_ticks_reg;

    // input register
    logic                    in_valid_reg;
    logic [CMD_W-1:0]        in_cmd_reg;
    logic [AXIS_W-1:0]       in_axis_reg;
    logic signed [VAL_W-1:0] in_value_reg;

    // run control
    logic              run_active_reg, run_active_next;
    logic              timeout_reg, timeout_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [TICK_W-1:0] elapsed_inc;

    // result register
    logic                out_valid_reg;
    logic [AXIS_NUM-1:0] out_done_reg;
    logic                out_all_reg;
    logic                out_timeout_reg;
    logic                out_closed_reg;
    logic [VAL_W-1:0]    out_range_reg;

    logic                advance;
    cmd_t                cmd;
    lane_cmd_t           lane_cmd  [AXIS_NUM];
    lane_stat_t          lane_stat [AXIS_NUM];
    logic [AXIS_NUM-1:0] done_vec;
    logic                all_next;
    logic                closed_any;
    logic [VAL_W-1:0]    range_any;

    // the item in the input register moves on when the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cmd           = cmd_t'(in_cmd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= DELTA_THRESHOLD_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELTA_THRESHOLD: threshold_reg     <= cfg_wdata[THR_W-1:0];
                CFG_TIMEOUT_TICKS:   timeout_ticks_reg <= cfg_wdata[TICK_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg   <= s_axis_tuser[1:0];
            in_axis_reg  <= s_axis_tuser[3:2];
            in_value_reg <= s_axis_tdata;
        end
    end

    // one lane per axis; the strobes fire only in the cycle the item is applied
    for (genvar i = 0; i < AXIS_NUM; i++)
    begin : g_lane
        always_comb
        begin
            lane_cmd[i].seed   = advance && (cmd == CMD_SEED)
                                 && (in_axis_reg == AXIS_W'(i));
            lane_cmd[i].sample = advance && (cmd == CMD_SAMPLE) && run_active_reg
                                 && (in_axis_reg == AXIS_W'(i));
            lane_cmd[i].value  = in_value_reg;
        end

        gdsd_axis_lane #(
            .WINDOW_SIZE (WINDOW_SIZE)
        ) u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .cmd             (lane_cmd[i]),
            .delta_threshold (threshold_reg),
            .stat            (lane_stat[i])
        );

        assign done_vec[i] = lane_stat[i].done;
    end

    always_comb
    begin
        all_next   = &done_vec;
        closed_any = 1'b0;
        range_any  = '0;
        // at most one lane is active, the others report zero
        for (int i = 0; i < AXIS_NUM; i++)
        begin
            closed_any = closed_any | lane_stat[i].closed;
            range_any  = range_any  | lane_stat[i].range;
        end

        // saturating elapsed count
        elapsed_inc = (elapsed_reg != '1) ? (elapsed_reg + TICK_W'(1)) : elapsed_reg;

        run_active_next = run_active_reg;
        timeout_next    = timeout_reg;
        elapsed_next    = elapsed_reg;

        if (advance)
        begin
            unique case (cmd)
                CMD_SEED:
                begin
                    if (in_axis_reg < AXIS_W'(AXIS_NUM))
                    begin
                        run_active_next = 1'b1;
                        timeout_next    = 1'b0;
                        elapsed_next    = '0;
                    end
                end
                CMD_SAMPLE:
                begin
                    // run ends once every axis has settled
                    if (run_active_reg && (in_axis_reg < AXIS_W'(AXIS_NUM)))
                    begin
                        run_active_next = !all_next;
                    end
                end
                CMD_TICK:
                begin
                    if (run_active_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= timeout_ticks_reg)
                        begin
                            timeout_next    = 1'b1;
                            run_active_next = 1'b0;
                        end
                    end
                end
                default: ;  // unused command code, no state change
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            timeout_reg    <= 1'b0;
            elapsed_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            run_active_reg <= run_active_next;
            timeout_reg    <= timeout_next;
            elapsed_reg    <= elapsed_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, status after the item is applied
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_done_reg    <= done_vec;
            out_all_reg     <= all_next;
            out_timeout_reg <= timeout_next;
            out_closed_reg  <= closed_any;
            out_range_reg   <= range_any;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_range_reg, out_timeout_reg, out_all_reg,
                            out_done_reg[2], out_done_reg[1], out_done_reg[0]};
    assign m_axis_tuser  = out_closed_reg;

endmodule

`default_nettype wire

// ===== sv/gdsd_checker.sv =====
`default_nettype none

module gdsd_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // no window evaluation means a zero range
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[20:5] == 16'd0))
        else $error("range reported without a window evaluation");

    // all_done is exactly the three axis flags together
    a_all_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[0] && m_axis_tdata[1]
                                               && m_axis_tdata[2])))
        else $error("all_done disagrees with axis flags");

    // a run cannot both succeed and time out
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
        else $error("success and timeout reported together");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind gyro_drift_settle_detector_core gdsd_checker u_gdsd_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    import gdsd_pkg::*;

    localparam int WINDOW      = 50;
    localparam int ITEM_TARGET = 800;
    // cycles without any transfer on either side before the run is declared hung
    localparam int STUCK_LIMIT = 1000;
    // cycles to let pass after the last result
    localparam int TAIL_CYCLES = 10;

    // codes the package leaves unnamed
    localparam logic [CMD_W-1:0]  CMD_NONE  = 2'd3;
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    // one expected status transfer
    typedef struct packed {
        logic             done_x;
        logic             done_y;
        logic             done_z;
        logic             all_done;
        logic             timed_out;
        logic             window_closed;
        logic [VAL_W-1:0] window_range;
    } status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [14:0] cfg_wdata = '0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // drift_value
    logic [3:0]  s_axis_tuser = '0;   // command, axis

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // done_x, done_y, done_z, all_done, timed_out,
                                      // window_range, zero pad
    logic        m_axis_tuser;        // window_closed

    gyro_drift_settle_detector_core #(
        .WINDOW_SIZE (WINDOW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // predicted detector state and the register copies it runs on
    logic signed [VAL_W-1:0] p_min [AXIS_NUM];
    logic signed [VAL_W-1:0] p_max [AXIS_NUM];
    logic [CNT_W-1:0]        p_cnt [AXIS_NUM];
    logic                    p_done [AXIS_NUM];
    logic [TICK_W-1:0]       p_elapsed;
    logic                    p_active;
    logic                    p_timeout;
    logic [THR_W-1:0]        p_thr = DELTA_THRESHOLD_RST;
    logic [TICK_W-1:0]       p_tmo = TIMEOUT_TICKS_RST;

    status_t status_q [$];   // status transfers still owed by the block
    status_t rx_exp;
    int      mismatch_cnt = 0;
    int      item_cnt = 0;
    int      burst_left = 0;
    int      rx_cyc = 0;
    int      rx_mode = 0;
    int      stuck = 0;

    initial
    begin
        for (int i = 0; i < AXIS_NUM; i++)
        begin
            p_min[i]  = '0;
            p_max[i]  = '0;
            p_cnt[i]  = '0;
            p_done[i] = 1'b0;
        end
        p_elapsed = '0;
        p_active  = 1'b0;
        p_timeout = 1'b0;
    end

    // apply one item to the predicted state and return the status it leaves
    function automatic status_t settle_predict(input logic [CMD_W-1:0] cmd,
                                               input logic [AXIS_W-1:0] ax,
                                               input logic [VAL_W-1:0] raw);
        status_t                 st;
        logic signed [VAL_W-1:0] v;
        int                      d;
        st = '0;
        v  = raw;
        if (cmd == CMD_SEED && ax != AXIS_NONE)
        begin
            // seed restarts the axis and the whole run timer
            p_min[ax]  = v;
            p_max[ax]  = v;
            p_cnt[ax]  = '0;
            p_done[ax] = 1'b0;
            p_active   = 1'b1;
            p_elapsed  = '0;
            p_timeout  = 1'b0;
        end
        else if (cmd == CMD_SAMPLE && ax != AXIS_NONE && p_active && !p_done[ax])
        begin
            if (p_cnt[ax] == WINDOW)
            begin
                // full window: judge its range, then restart at this sample
                d = int'(p_max[ax]) - int'(p_min[ax]);
                st.window_range  = d[VAL_W-1:0];
                st.window_closed = 1'b1;
                if (d != 0 && d < int'(p_thr))
                    p_done[ax] = 1'b1;
                p_min[ax] = v;
                p_max[ax] = v;
                p_cnt[ax] = '0;
            end
            if (v < p_min[ax])
                p_min[ax] = v;
            if (v > p_max[ax])
                p_max[ax] = v;
            p_cnt[ax] = p_cnt[ax] + 1'b1;
            if (p_done[0] && p_done[1] && p_done[2])
                p_active = 1'b0;
        end
        else if (cmd == CMD_TICK && p_active)
        begin
            if (p_elapsed != {TICK_W{1'b1}})
                p_elapsed = p_elapsed + 1'b1;
            if (p_elapsed >= p_tmo)
            begin
                p_timeout = 1'b1;
                p_active  = 1'b0;
            end
        end
        st.done_x    = p_done[0];
        st.done_y    = p_done[1];
        st.done_z    = p_done[2];
        st.all_done  = p_done[0] && p_done[1] && p_done[2];
        st.timed_out = p_timeout;
        return st;
    endfunction

    // offer one item, in bursts with random gaps, and log its expected status
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [AXIS_W-1:0] ax,
                             input logic [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= {ax, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        status_q.push_back(settle_predict(cmd, ax, val));
        item_cnt++;
    endtask

    // stop offering and wait for every owed status transfer
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        burst_left = 0;
    endtask

    // register write, only ever with the block idle
    task automatic write_reg(input logic idx, input logic [14:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_DELTA_THRESHOLD)
            p_thr = val[THR_W-1:0];
        else
            p_tmo = val;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // everything before the first seed is ignored
    task automatic test_before_seed();
        send_item(CMD_SAMPLE, AXIS_X, 16'h1234);
        send_item(CMD_TICK, AXIS_Y, 16'h0000);
        send_item(CMD_NONE, AXIS_X, 16'hFFFF);
        send_item(CMD_SEED, AXIS_NONE, 16'h5555);
        send_item(CMD_SAMPLE, AXIS_NONE, 16'hAAAA);
    endtask

    // seeds and samples at the value extremes, with invalid codes mixed in
    task automatic test_seed_extremes();
        send_item(CMD_SEED, AXIS_X, 16'h8000);
        send_item(CMD_SEED, AXIS_Y, 16'h7FFF);
        send_item(CMD_SEED, AXIS_Z, 16'h0000);
        send_item(CMD_SAMPLE, AXIS_X, 16'h7FFF);
        send_item(CMD_SAMPLE, AXIS_Y, 16'h8000);
        send_item(CMD_SAMPLE, AXIS_Z, 16'hFFFF);
        send_item(CMD_SAMPLE, AXIS_NONE, 16'h7FFF);
        send_item(CMD_NONE, AXIS_Z, 16'h8000);
        send_item(CMD_TICK, AXIS_NONE, 16'hFFFF);
    endtask

    // zero timeout: the first tick of a run ends it
    task automatic test_zero_timeout();
        write_reg(CFG_TIMEOUT_TICKS, 15'd0);
        send_item(CMD_SEED, AXIS_X, 16'h0010);
        send_item(CMD_TICK, AXIS_X, 16'h0000);
        send_item(CMD_SAMPLE, AXIS_X, 16'h0011);
        send_item(CMD_TICK, AXIS_Z, 16'h0000);
        send_item(CMD_SEED, AXIS_Y, 16'hFFF0);
        send_item(CMD_TICK, AXIS_Y, 16'h0000);
    endtask

    // a short timeout reached partway through a run
    task automatic test_timeout();
        write_reg(CFG_DELTA_THRESHOLD, 15'(DELTA_THRESHOLD_RST));
        write_reg(CFG_TIMEOUT_TICKS, 15'd100);
        send_item(CMD_SEED, AXIS_X, 16'($urandom));
        send_item(CMD_SEED, AXIS_Y, 16'($urandom));
        send_item(CMD_SEED, AXIS_Z, 16'($urandom));
        for (int i = 0; i < 140; i++)
        begin
            if (i % 4 == 3)
                send_item(CMD_SAMPLE, 2'($urandom_range(0, 2)), 16'($urandom));
            else
                send_item(CMD_TICK, 2'($urandom), 16'($urandom));
        end
        // a new seed clears the timeout and starts over
        send_item(CMD_SEED, AXIS_Z, 16'($urandom));
        send_item(CMD_TICK, AXIS_X, 16'($urandom));
        write_reg(CFG_TIMEOUT_TICKS, 15'h7FFF);
    endtask

    // full runs: seed all axes, then windows of samples with a chosen spread each
    task automatic test_settle_runs();
        int         base [AXIS_NUM];
        int         spread [AXIS_NUM];
        int         n_samples;
        int         pick;
        int         thr_i;
        logic [1:0] ax;
        while (item_cnt < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 5);
            case (pick)
                0: write_reg(CFG_DELTA_THRESHOLD, 15'd1);
                1: write_reg(CFG_DELTA_THRESHOLD, 15'd500);
                2: write_reg(CFG_DELTA_THRESHOLD, 15'd511);
                default: write_reg(CFG_DELTA_THRESHOLD, 15'($urandom_range(2, 499)));
            endcase
            pick = $urandom_range(0, 5);
            if (pick == 0)
                write_reg(CFG_TIMEOUT_TICKS, 15'($urandom_range(100, 400)));
            else if (pick == 1)
                write_reg(CFG_TIMEOUT_TICKS, 15'h7FFF);
            else
                write_reg(CFG_TIMEOUT_TICKS, 15'd30000);
            thr_i = p_thr;
            for (int i = 0; i < AXIS_NUM; i++)
            begin
                // flat, settling, near the threshold, or full scale
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    spread[i] = 0;
                else if (pick < 13)
                    spread[i] = $urandom_range(1, (thr_i > 1) ? thr_i - 1 : 1);
                else if (pick < 16)
                    spread[i] = thr_i + $urandom_range(0, 2) - 1;
                else
                    spread[i] = 65535;
                base[i] = $urandom_range(0, 65535 - spread[i]);
                base[i] = base[i] - 32768;
                send_item(CMD_SEED, 2'(i), 16'(base[i] + $urandom_range(0, spread[i])));
            end
            n_samples = $urandom_range(160, 260);
            // keep the total close to the item target
            if (n_samples > ITEM_TARGET - item_cnt)
                n_samples = (ITEM_TARGET - item_cnt > 0) ? ITEM_TARGET - item_cnt : 1;
            for (int i = 0; i < n_samples; i++)
            begin
                pick = $urandom_range(0, 99);
                ax   = 2'($urandom_range(0, 2));
                if (pick < 8)
                    send_item(CMD_TICK, 2'($urandom), 16'($urandom));
                else if (pick < 12)
                    send_item(2'($urandom), 2'($urandom), 16'($urandom));
                else if (pick < 13)
                    send_item(CMD_SEED, ax, 16'(base[ax] + $urandom_range(0, spread[ax])));
                else
                    send_item(CMD_SAMPLE, ax, 16'(base[ax] + $urandom_range(0, spread[ax])));
            end
            if ($urandom_range(0, 2) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_seed();
        test_seed_extremes();
        test_zero_timeout();
        test_timeout();
        test_settle_runs();
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // result side: check each status transfer, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (status_q.size() == 0)
            begin
                $error("status transfer with nothing expected");
                mismatch_cnt++;
            end
            else
            begin
                rx_exp = status_q.pop_front();
                check_field("done_x", rx_exp.done_x, m_axis_tdata[0]);
                check_field("done_y", rx_exp.done_y, m_axis_tdata[1]);
                check_field("done_z", rx_exp.done_z, m_axis_tdata[2]);
                check_field("all_done", rx_exp.all_done, m_axis_tdata[3]);
                check_field("timed_out", rx_exp.timed_out, m_axis_tdata[4]);
                check_field("window_range", rx_exp.window_range, m_axis_tdata[20:5]);
                check_field("window_closed", rx_exp.window_closed, m_axis_tuser);
            end
        end
        // stall style changes every so often: none, random, periodic, heavy
        rx_cyc++;
        if (rx_cyc % 150 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= (rx_cyc % 8 < 5);
            default: m_axis_tready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    // hang detection: too long without a transfer on either side
    initial
    begin
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
